>>> hdl/cda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_pkg
// Shared opcodes, limits, handshake structs and calendar helper functions
// for the calendar date arithmetic block.
// ----------------------------------------------------------------------------
package cda_pkg;

   localparam logic [2:0] OP_NEXT  = 3'd0;
   localparam logic [2:0] OP_PREV  = 3'd1;
   localparam logic [2:0] OP_ADD   = 3'd2;
   localparam logic [2:0] OP_SUB   = 3'd3;
   localparam logic [2:0] OP_JAN1  = 3'd4;
   localparam logic [2:0] OP_YEARS = 3'd5;
   localparam logic [2:0] OP_PASS  = 3'd7;

   localparam logic [11:0] YEAR_MIN  = 12'd1800;
   localparam logic [11:0] YEAR_MAX  = 12'd2999;
   localparam logic [11:0] YEAR_BASE = 12'd1900;
   localparam logic [10:0] QUAD_DAYS = 11'd1461;

   localparam int ERR_DAY   = 0;
   localparam int ERR_MONTH = 1;
   localparam int ERR_YEAR  = 2;

   localparam logic [8:0] MONTH_START [0:9] = '{
      9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   typedef struct packed {
      logic       start;
      logic [2:0] op;
   } walk_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } walk_stat_type;

   // y / 100 by reciprocal, exact for all 12-bit years
   function automatic logic is_leap(input logic [11:0] y);
      logic [24:0] prod;
      logic [5:0]  q;
      logic [11:0] r;
      prod = 25'(y) * 25'd5243;
      q    = prod[24:19];
      r    = y - (12'(q) * 12'd100);
      return (y[1:0] == 2'd0) && ((r != 12'd0) || (q[1:0] == 2'd0));
   endfunction

   function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [11:0] y);
      logic [4:0] dim;
      case (m)
         4'd2: begin
            dim = is_leap(y) ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            dim = 5'd30;
         end
         default: begin
            dim = 5'd31;
         end
      endcase
      return dim;
   endfunction

   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] ofs;
      case (m)
         4'd0, 4'd1: begin
            ofs = 9'd0;
         end
         4'd2: begin
            ofs = 9'd31;
         end
         4'd13: begin
            ofs = MONTH_START[0];
         end
         4'd14: begin
            ofs = MONTH_START[1];
         end
         4'd15: begin
            ofs = MONTH_START[2];
         end
         default: begin
            ofs = MONTH_START[4'(m - 4'd3)];
         end
      endcase
      return ofs;
   endfunction

endpackage

>>> hdl/cda_daynum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_daynum
// Two-stage day-of-year and serial day number of the accepted date:
// table lookup and scaled year product, then quarter and offset.
// ----------------------------------------------------------------------------
module cda_daynum (
   input  logic               clock,
   input  logic               load,
   input  logic        [5:0]  in_day,
   input  logic        [3:0]  in_month,
   input  logic        [11:0] in_year,
   output logic        [8:0]  day_of_year,
   output logic signed [19:0] serial_day
);
   import cda_pkg::*;

   logic        [8:0]  doy_ff, doy_in;
   logic signed [23:0] prod_ff, prod_in;
   logic signed [19:0] serial_ff, serial_in;
   logic signed [12:0] ydiff;
   logic signed [23:0] ydiff_ext;
   logic signed [23:0] quarter;
   logic               leap_adj;

   always_comb begin
      leap_adj  = is_leap(in_year) && (in_month >= 4'd3);
      doy_in    = 9'(in_day) + month_offset(in_month) + 9'(leap_adj);
      ydiff     = $signed({1'b0, in_year}) - $signed({1'b0, YEAR_BASE});
      ydiff_ext = {{11{ydiff[12]}}, ydiff};
      prod_in   = ydiff_ext * $signed({13'd0, QUAD_DAYS});
   end

   // quarter truncated toward zero
   always_comb begin
      if (prod_ff < 0) begin
         quarter = (prod_ff + 24'sd3) >>> 2;
      end else begin
         quarter = prod_ff >>> 2;
      end
      serial_in = quarter[19:0] + $signed({11'd0, doy_ff}) - 20'sd2;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         doy_ff  <= doy_in;
         prod_ff <= prod_in;
      end
      serial_ff <= serial_in;
   end

   assign day_of_year = doy_ff;
   assign serial_day  = serial_ff;

endmodule

>>> hdl/cda_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_walk
// Date sequencer: one shared month-length lookup and day adder stepped
// one month per cycle until the day count lands inside a month.
// ----------------------------------------------------------------------------
module cda_walk (
   input  logic                   clock,
   input  logic                   reset,
   input  cda_pkg::walk_cmd_type  cmd,
   input  logic        [5:0]      in_day,
   input  logic        [3:0]      in_month,
   input  logic        [11:0]     in_year,
   input  logic        [15:0]     day_count,
   input  logic signed [11:0]     year_delta,
   output cda_pkg::walk_stat_type stat,
   output logic        [4:0]      res_day,
   output logic        [3:0]      res_month,
   output logic signed [13:0]     res_year
);
   import cda_pkg::*;

   localparam logic WK_IDLE = 1'b0;
   localparam logic WK_RUN  = 1'b1;

   logic               state_ff, state_in;
   logic        [2:0]  op_ff, op_in;
   logic signed [17:0] t_ff, t_in;
   logic        [3:0]  m_ff, m_in;
   logic signed [13:0] y_ff, y_in;
   logic signed [11:0] delta_ff, delta_in;

   logic signed [17:0] d18, c18, dim18, sum;
   logic        [3:0]  prev_m, next_m, sel_m;
   logic signed [13:0] prev_y, next_y, sel_y;
   logic        [4:0]  dim;
   logic               leap_sel, finish;

   always_comb begin
      d18    = {12'd0, in_day};
      c18    = {2'd0, day_count};
      prev_m = (m_ff == 4'd1) ? 4'd12 : m_ff - 4'd1;
      prev_y = (m_ff == 4'd1) ? y_ff - 14'sd1 : y_ff;
      next_m = (m_ff == 4'd12) ? 4'd1 : m_ff + 4'd1;
      next_y = (m_ff == 4'd12) ? y_ff + 14'sd1 : y_ff;
      sel_m  = (op_ff == OP_SUB) ? prev_m : m_ff;
      sel_y  = (op_ff == OP_SUB) ? prev_y : y_ff;
      dim      = days_in_month(sel_m, sel_y[11:0]);
      leap_sel = is_leap(sel_y[11:0]);
      dim18    = {13'd0, dim};
      sum      = (op_ff == OP_SUB) ? t_ff + dim18 : t_ff - dim18;
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      t_in     = t_ff;
      m_in     = m_ff;
      y_in     = y_ff;
      delta_in = delta_ff;
      finish   = 1'b0;
      if (state_ff == WK_IDLE) begin
         if (cmd.start) begin
            state_in = WK_RUN;
            m_in     = in_month;
            y_in     = {2'd0, in_year};
            delta_in = year_delta;
            op_in    = cmd.op;
            t_in     = d18;
            case (cmd.op)
               OP_NEXT: begin
                  t_in = d18 + 18'sd1;
               end
               OP_PREV: begin
                  t_in  = d18 - 18'sd1;
                  op_in = OP_SUB;
               end
               OP_ADD: begin
                  t_in = d18 + c18;
               end
               OP_SUB: begin
                  t_in = d18 - c18;
               end
               default: begin
                  t_in = d18;
               end
            endcase
         end
      end else begin
         case (op_ff)
            OP_ADD: begin
               if (t_ff > dim18) begin
                  t_in = sum;
                  m_in = next_m;
                  y_in = next_y;
               end else begin
                  finish = 1'b1;
               end
            end
            OP_NEXT: begin
               if (t_ff > dim18) begin
                  t_in = 18'sd1;
                  m_in = next_m;
                  y_in = next_y;
               end
               finish = 1'b1;
            end
            OP_SUB: begin
               if (t_ff < 18'sd1) begin
                  t_in = sum;
                  m_in = prev_m;
                  y_in = prev_y;
               end else begin
                  finish = 1'b1;
               end
            end
            OP_JAN1: begin
               t_in   = 18'sd1;
               m_in   = 4'd1;
               finish = 1'b1;
            end
            OP_YEARS: begin
               if ((m_ff == 4'd2) && (t_ff == 18'sd29) && leap_sel) begin
                  t_in = 18'sd28;
               end
               y_in   = y_ff + {{2{delta_ff[11]}}, delta_ff};
               finish = 1'b1;
            end
            default: begin
               finish = 1'b1;
            end
         endcase
         if (finish) begin
            state_in = WK_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WK_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff    <= op_in;
      t_ff     <= t_in;
      m_ff     <= m_in;
      y_ff     <= y_in;
      delta_ff <= delta_in;
   end

   assign stat.busy = (state_ff == WK_RUN);
   assign stat.done = (state_ff == WK_RUN) && finish;
   assign res_day   = t_ff[4:0];
   assign res_month = m_ff;
   assign res_year  = y_ff;

endmodule

>>> hdl/calendar_date_arithmetic_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_arithmetic_top
// Sequence: accept, the walker crossing n months (about 2160 at most for a
// 65535-day add or subtract, else 0 or 1), then rsp_tvalid with the result.
// Throughput: one transaction in flight; the month walker steps one month per
// cycle and req_tready returns once the result sits in the output register.
// Reset: synchronous, clears the sequencer and output valid; no clearing pass.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode, in_day, in_month, in_year, day_count, year_delta, zero fill
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_day, out_month, out_year, day_of_year, serial_day, zero fill
   output logic [55:0] rsp_tdata,
   // input_error, result_out_of_range
   output logic [3:0]  rsp_tuser
);
   import cda_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  err_ff, err_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [55:0] rsp_tdata_ff, rsp_tdata_in;
   logic [3:0]  rsp_tuser_ff, rsp_tuser_in;

   logic               accept, out_load, oor;
   logic        [2:0]  req_op;
   logic        [5:0]  req_day;
   logic        [3:0]  req_month;
   logic        [11:0] req_year;
   logic        [15:0] req_count;
   logic signed [11:0] req_delta;
   logic        [11:0] sat_year;
   logic        [4:0]  res_day;
   logic        [3:0]  res_month;
   logic signed [13:0] res_year;
   logic        [8:0]  doy;
   logic signed [19:0] serial;
   walk_cmd_type       walk_cmd;
   walk_stat_type      walk_stat;

   assign req_op    = req_tdata[2:0];
   assign req_day   = req_tdata[8:3];
   assign req_month = req_tdata[12:9];
   assign req_year  = req_tdata[24:13];
   assign req_count = req_tdata[40:25];
   assign req_delta = req_tdata[52:41];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_load   = (state_ff == ST_DONE) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      err_in            = 3'd0;
      err_in[ERR_DAY]   = (req_day < 6'd1) || (req_day > 6'd31);
      err_in[ERR_MONTH] = (req_month < 4'd1) || (req_month > 4'd12);
      err_in[ERR_YEAR]  = (req_year < YEAR_MIN) || (req_year > YEAR_MAX);
      walk_cmd.start    = accept;
      walk_cmd.op       = (err_in != 3'd0) ? OP_PASS : req_op;
   end

   cda_walk u_walk (
      .clock      (clock),
      .reset      (reset),
      .cmd        (walk_cmd),
      .in_day     (req_day),
      .in_month   (req_month),
      .in_year    (req_year),
      .day_count  (req_count),
      .year_delta (req_delta),
      .stat       (walk_stat),
      .res_day    (res_day),
      .res_month  (res_month),
      .res_year   (res_year)
   );

   cda_daynum u_daynum (
      .clock       (clock),
      .load        (accept),
      .in_day      (req_day),
      .in_month    (req_month),
      .in_year     (req_year),
      .day_of_year (doy),
      .serial_day  (serial)
   );

   always_comb begin
      if (res_year < 14'sd0) begin
         sat_year = 12'd0;
      end else if (res_year > 14'sd4095) begin
         sat_year = 12'd4095;
      end else begin
         sat_year = res_year[11:0];
      end
      oor = (res_year < $signed({2'b00, YEAR_MIN})) || (res_year > $signed({2'b00, YEAR_MAX}));
   end

   always_comb begin
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (walk_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in      = ST_IDLE;
               rsp_tvalid_in = 1'b1;
               if (err_ff != 3'd0) begin
                  rsp_tdata_in = 56'd0;
                  rsp_tuser_in = {1'b0, err_ff};
               end else begin
                  rsp_tdata_in = {6'd0, serial, doy, sat_year, res_month, res_day};
                  rsp_tuser_in = {oor, 3'd0};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      if (accept) begin
         err_ff <= err_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted while a transaction is in flight");

   a_walk_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      walk_stat.busy |-> (state_ff == ST_BUSY))
      else $error("date walker running outside the busy state");

   a_error_zeroes_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[2:0] != 3'd0)) |-> ((rsp_tdata == 56'd0) && !rsp_tuser[3]))
      else $error("invalid input produced a nonzero result");

   a_valid_result_date: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[2:0] == 3'd0)) |->
         ((rsp_tdata[4:0] != 5'd0) && (rsp_tdata[8:5] >= 4'd1) && (rsp_tdata[8:5] <= 4'd12)))
      else $error("result date has an impossible day or month");

endmodule
